// ===== hw/rtl/sbi_pkg.sv =====
`default_nettype none
package sbi_pkg;

  // default coordinate width (Q16.16)
  localparam int COORD_WIDTH_DEF = 32;

  // half extent after reset: 1.0 in Q16.16
  localparam int HALF_RESET = 65536;

  // register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_HALF_X   = 3'd3;
  localparam logic [2:0] REG_HALF_Y   = 3'd4;
  localparam logic [2:0] REG_HALF_Z   = 3'd5;

  // wall codes
  localparam logic [2:0] WALL_NEG_X = 3'd0;
  localparam logic [2:0] WALL_NEG_Y = 3'd1;
  localparam logic [2:0] WALL_NEG_Z = 3'd2;
  localparam logic [2:0] WALL_POS_X = 3'd3;
  localparam logic [2:0] WALL_POS_Y = 3'd4;
  localparam logic [2:0] WALL_POS_Z = 3'd5;

endpackage
`default_nettype wire

// ===== hw/rtl/sbi_udiv.sv =====
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Expects num < den * 2**W so the quotient fits W bits.
module sbi_udiv #(
  parameter int W = sbi_pkg::COORD_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   ld,
  input  wire logic [2*W-1:0] num,
  input  wire logic [W-1:0]   den,
  output logic      [W-1:0]   quo
);

  logic [W-1:0] rem [W];
  logic [W-1:0] lq  [W];
  logic [W-1:0] dv  [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W-1:0] pr, plq, pd;
    logic [W:0]   t, diff;
    logic         ge;

    // previous partial remainder, or the upper numerator half on entry
    if (k == 0) begin : g_first
      assign pr  = num[2*W-1:W];
      assign plq = num[W-1:0];
      assign pd  = den;
    end else begin : g_next
      assign pr  = rem[k-1];
      assign plq = lq[k-1];
      assign pd  = dv[k-1];
    end

    // shift in one bit, compare and subtract
    always_comb begin
      t    = {pr, plq[W-1]};
      diff = t - {1'b0, pd};
      ge   = (t >= {1'b0, pd});
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem[k] <= ge ? diff[W-1:0] : t[W-1:0];
        lq[k]  <= {plq[W-2:0], ge};
        dv[k]  <= pd;
      end
    end
  end

  assign quo = lq[W-1];

endmodule
`default_nettype wire

// ===== hw/rtl/segment_box_intersect.sv =====
`default_nettype none
// Segment versus axis-aligned box test.
// Input stream s_*: one segment per request, start and end points.
// Output stream m_*: one result per segment, in order: hit flag, start inside
// flag, wall code and hit point (saturated to the coordinate width).
// Box centre and half extents sit in six APB registers; the user must write
// them only while idle, and the block itself does not enforce this.
// The divider contributes one stage per quotient bit, the rest is offset,
// outcode, magnitude, multiply, interpolate and select stages.
// Throughput: one segment per cycle unless m_tready is low and the pipeline
// is full; every stage holds a valid bit and advances on its own, so bubbles
// are squeezed out. When m_tready is low the last stage holds its result and
// the stages in front keep filling until the pipeline is full; only then does
// s_tready drop. Nothing is lost or repeated.
// Reset clears the valid bits, centre to zero and half extents to 1.0.
module segment_box_intersect #(
  parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  // configuration
  input  wire logic                                       psel,
  input  wire logic                                       penable,
  input  wire logic                                       pwrite,
  input  wire logic [$clog2(6*((COORD_WIDTH > 32) ? 8 : 4))-1:0] paddr,
  input  wire logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic      [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                            pready,
  // segment requests
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (low bits first)
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
  // results
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // hit, start_inside, wall[2:0], point_x, point_y, point_z (low bits first)
  output logic      [((5+3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata
);

  localparam int W   = COORD_WIDTH;
  localparam int PW  = (W > 32) ? 64 : 32;
  localparam int AW  = $clog2(6*(PW/8));
  localparam int IB  = $clog2(PW/8);
  localparam int MW  = ((5+3*W+7)/8)*8;
  localparam int NS  = W + 6;
  localparam int ST_DIV = 4;
  localparam int ST_X   = W + 4;
  localparam int ST_O   = W + 5;
  localparam logic [W-2:0] HRST = (W-1)'(sbi_pkg::HALF_RESET);

  typedef struct packed {
    logic                miss;
    logic                ins;
    logic [2:0]          cand;
    logic [2:0]          side;
    logic [5:0]          neg;
    logic [2:0][W:0]     a;
    logic [2:0][W-1:0]   st;
  } side_t;

  function automatic logic [W-1:0] sat(input logic [W+1:0] v);
    logic [W-1:0] r;
    if ((v[W+1:W-1] == 3'b000) || (v[W+1:W-1] == 3'b111)) begin
      r = v[W-1:0];
    end else if (v[W+1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [W-1:0] cen [3];
  logic [W-2:0] hlf [3];
  logic [2:0]   idx;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign idx    = paddr[AW-1:IB];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cen[i] <= '0;
        hlf[i] <= HRST;
      end
    end else if (cfg_wr) begin
      unique case (idx)
        sbi_pkg::REG_CENTER_X: cen[0] <= pwdata[W-1:0];
        sbi_pkg::REG_CENTER_Y: cen[1] <= pwdata[W-1:0];
        sbi_pkg::REG_CENTER_Z: cen[2] <= pwdata[W-1:0];
        sbi_pkg::REG_HALF_X:   hlf[0] <= pwdata[W-2:0];
        sbi_pkg::REG_HALF_Y:   hlf[1] <= pwdata[W-2:0];
        sbi_pkg::REG_HALF_Z:   hlf[2] <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (idx)
      sbi_pkg::REG_CENTER_X: prdata = PW'(cen[0]);
      sbi_pkg::REG_CENTER_Y: prdata = PW'(cen[1]);
      sbi_pkg::REG_CENTER_Z: prdata = PW'(cen[2]);
      sbi_pkg::REG_HALF_X:   prdata = PW'(hlf[0]);
      sbi_pkg::REG_HALF_Y:   prdata = PW'(hlf[1]);
      sbi_pkg::REG_HALF_Z:   prdata = PW'(hlf[2]);
      default:               prdata = '0;
    endcase
  end

  // ------------------------------------------------------- flow control
  logic [NS-1:0] v;
  logic [NS:0]   rdy;
  logic [NS-1:0] ld;

  always_comb begin
    rdy[NS] = m_tready;
    for (int k = NS-1; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign ld       = rdy[NS-1:0];
  assign s_tready = rdy[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ld[k]) begin
          v[k] <= (k == 0) ? s_tvalid : v[k-1];
        end
      end
    end
  end

  // ------------------------------------- stage 0: offsets from the centre
  logic [W-1:0] sx [3];
  logic [W-1:0] ex [3];
  logic [W:0]   a0 [3];
  logic [W:0]   b0 [3];
  logic [W-1:0] st0 [3];

  for (genvar i = 0; i < 3; i++) begin : g_split
    assign sx[i] = s_tdata[i*W +: W];
    assign ex[i] = s_tdata[(3+i)*W +: W];
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        a0[i]  <= {sx[i][W-1], sx[i]} - {cen[i][W-1], cen[i]};
        b0[i]  <= {ex[i][W-1], ex[i]} - {cen[i][W-1], cen[i]};
        st0[i] <= sx[i];
      end
    end
  end

  // ------------------------- stage 1: outcodes, direction, wall distance
  logic [W:0]   hp [3];
  logic [W:0]   hn [3];
  logic [2:0]   alo, ahi, blo, bhi;
  logic [W:0]   wv [3];
  logic [W+1:0] nn [3];
  logic [5:0]   oa1, ob1;
  logic [W:0]   d1 [3];
  logic [W+1:0] n1 [3];
  logic [W:0]   a1 [3];
  logic [W-1:0] st1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hp[i]  = {2'b00, hlf[i]};
      hn[i]  = -hp[i];
      alo[i] = $signed(a0[i]) < $signed(hn[i]);
      ahi[i] = $signed(a0[i]) > $signed(hp[i]);
      blo[i] = $signed(b0[i]) < $signed(hn[i]);
      bhi[i] = $signed(b0[i]) > $signed(hp[i]);
      wv[i]  = alo[i] ? hn[i] : hp[i];
      nn[i]  = {wv[i][W], wv[i]} - {a0[i][W], a0[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      oa1 <= {ahi, alo};
      ob1 <= {bhi, blo};
      for (int i = 0; i < 3; i++) begin
        d1[i]  <= b0[i] - a0[i];
        n1[i]  <= nn[i];
        a1[i]  <= a0[i];
        st1[i] <= st0[i];
      end
    end
  end

  // ---------------------------------------------- stage 2: magnitudes
  logic [W+1:0] nab [3];
  logic [W:0]   dab [3];
  logic [W-1:0] nm2 [3];
  logic [W-1:0] dm2 [3];
  logic [2:0]   sn2, sd2, cand2, side2;
  logic         miss2, ins2;
  logic [W:0]   a2 [3];
  logic [W-1:0] st2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nab[i] = n1[i][W+1] ? -n1[i] : n1[i];
      dab[i] = d1[i][W] ? -d1[i] : d1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      miss2 <= |(oa1 & ob1);
      ins2  <= (oa1 == '0);
      for (int i = 0; i < 3; i++) begin
        nm2[i]   <= nab[i][W-1:0];
        dm2[i]   <= dab[i][W-1:0];
        sn2[i]   <= n1[i][W+1];
        sd2[i]   <= d1[i][W];
        cand2[i] <= oa1[i] | oa1[i+3];
        side2[i] <= oa1[i+3];
        a2[i]    <= a1[i];
        st2[i]   <= st1[i];
      end
    end
  end

  // ------------------------------------ stage 3: distance times slope
  logic [2*W-1:0] p3 [6];
  logic [W-1:0]   dv3 [3];
  side_t          sb3;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      sb3.miss <= miss2;
      sb3.ins  <= ins2;
      sb3.cand <= cand2;
      sb3.side <= side2;
      for (int i = 0; i < 3; i++) begin
        dv3[i]    <= dm2[i];
        sb3.a[i]  <= a2[i];
        sb3.st[i] <= st2[i];
        for (int k = 0; k < 2; k++) begin
          p3[2*i+k] <= (2*W)'(nm2[i]) *
                       (2*W)'(dm2[(i+1+k >= 3) ? i+k-2 : i+1+k]);
          sb3.neg[2*i+k] <= sn2[i] ^ sd2[(i+1+k >= 3) ? i+k-2 : i+1+k] ^ sd2[i];
        end
      end
    end
  end

  // --------------------------------- divider stages, sideband alongside
  logic [W-1:0] qd [6];
  side_t        sbd [W];

  for (genvar l = 0; l < 6; l++) begin : g_div
    sbi_udiv #(.W(W)) u_div (
      .clk (clk),
      .ld  (ld[ST_DIV +: W]),
      .num (p3[l]),
      .den (dv3[l/2]),
      .quo (qd[l])
    );
  end

  for (genvar k = 0; k < W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (ld[ST_DIV+k]) begin
        if (k == 0) begin
          sbd[k] <= sb3;
        end else begin
          sbd[k] <= sbd[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // ------------------------- stage X: crossing point and extent check
  side_t        sdx;
  logic [W+1:0] qe [6];
  logic [W+1:0] xv [6];
  logic [W+1:0] pv [6];
  logic [W+1:0] he [6];
  logic [5:0]   inr;
  logic [W:0]   wp [3];
  logic [2:0]   okx;
  logic [W+1:0] ptx [6];
  logic [W:0]   wpx [3];
  logic         missx, insx;
  logic [2:0]   sidex;
  logic [W-1:0] stx [3];

  assign sdx = sbd[W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 2; k++) begin
        qe[2*i+k] = {2'b00, qd[2*i+k]};
        he[2*i+k] = {3'b000, hlf[(i+1+k >= 3) ? i+k-2 : i+1+k]};
        xv[2*i+k] = sdx.neg[2*i+k]
          ? {sdx.a[(i+1+k >= 3) ? i+k-2 : i+1+k][W],
             sdx.a[(i+1+k >= 3) ? i+k-2 : i+1+k]} - qe[2*i+k]
          : {sdx.a[(i+1+k >= 3) ? i+k-2 : i+1+k][W],
             sdx.a[(i+1+k >= 3) ? i+k-2 : i+1+k]} + qe[2*i+k];
        pv[2*i+k] = sdx.neg[2*i+k]
          ? {{2{sdx.st[(i+1+k >= 3) ? i+k-2 : i+1+k][W-1]}},
             sdx.st[(i+1+k >= 3) ? i+k-2 : i+1+k]} - qe[2*i+k]
          : {{2{sdx.st[(i+1+k >= 3) ? i+k-2 : i+1+k][W-1]}},
             sdx.st[(i+1+k >= 3) ? i+k-2 : i+1+k]} + qe[2*i+k];
        inr[2*i+k] = !($signed(xv[2*i+k]) > $signed(he[2*i+k])) &&
                     !($signed(xv[2*i+k]) < -$signed(he[2*i+k]));
      end
      // wall plane in absolute coordinates
      wp[i] = sdx.side[i] ? {cen[i][W-1], cen[i]} + {2'b00, hlf[i]}
                          : {cen[i][W-1], cen[i]} - {2'b00, hlf[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_X]) begin
      missx <= sdx.miss;
      insx  <= sdx.ins;
      sidex <= sdx.side;
      for (int i = 0; i < 3; i++) begin
        okx[i] <= sdx.cand[i] & inr[2*i] & inr[2*i+1];
        wpx[i] <= wp[i];
        stx[i] <= sdx.st[i];
      end
      for (int l = 0; l < 6; l++) begin
        ptx[l] <= pv[l];
      end
    end
  end

  // -------------------------- stage O: first wall that holds, saturate
  logic         nh, ni, found;
  logic [2:0]   nw;
  logic [W-1:0] npt [3];
  logic [W-1:0] sw [3];
  logic [W-1:0] sp [6];
  logic         o_hit, o_ins;
  logic [2:0]   o_wall;
  logic [W-1:0] o_pt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sw[i] = sat({wpx[i][W], wpx[i]});
    end
    for (int l = 0; l < 6; l++) begin
      sp[l] = sat(ptx[l]);
    end
    nh    = 1'b0;
    ni    = 1'b0;
    found = 1'b0;
    nw    = sbi_pkg::WALL_NEG_X;
    for (int i = 0; i < 3; i++) begin
      npt[i] = '0;
    end
    priority if (missx) begin
      nh = 1'b0;
    end else if (insx) begin
      nh = 1'b1;
      ni = 1'b1;
      for (int i = 0; i < 3; i++) begin
        npt[i] = stx[i];
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (!found && okx[i]) begin
          found = 1'b1;
          nh    = 1'b1;
          nw    = sidex[i] ? 3'(sbi_pkg::WALL_POS_X + 3'(i))
                           : 3'(sbi_pkg::WALL_NEG_X + 3'(i));
          npt[i] = sw[i];
          npt[(i+1 >= 3) ? i-2 : i+1] = sp[2*i];
          npt[(i+2 >= 3) ? i-1 : i+2] = sp[2*i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[ST_O]) begin
      o_hit  <= nh;
      o_ins  <= ni;
      o_wall <= nw;
      for (int i = 0; i < 3; i++) begin
        o_pt[i] <= npt[i];
      end
    end
  end

  assign m_tdata = MW'({o_pt[2], o_pt[1], o_pt[0], o_wall, o_ins, o_hit});

  // ---------------------------------------------------------- checks
  a_ins_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && o_ins |-> o_hit && (o_wall == sbi_pkg::WALL_NEG_X))
    else $error("start inside without hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_hit |-> !o_ins && (o_wall == sbi_pkg::WALL_NEG_X) &&
      (o_pt[0] == '0) && (o_pt[1] == '0) && (o_pt[2] == '0))
    else $error("miss carries a non-zero result");

  a_wall_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_wall <= sbi_pkg::WALL_POS_Z))
    else $error("wall code out of range");

endmodule
`default_nettype wire
